/* design/u8d_pkg.sv */
`default_nettype none

package u8d_pkg;

    // code point width and replacement character
    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    // lead byte classes
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;

    // number of continuation bytes a lead asks for, zero when not a lead
    function automatic logic [1:0] lead_extra(input logic [7:0] b);
        logic [1:0] extra;
        priority if (b >= LEAD4_MIN)
            extra = 2'd3;
        else if (b >= LEAD3_MIN)
            extra = 2'd2;
        else if (b >= LEAD2_MIN)
            extra = 2'd1;
        else
            extra = 2'd0;
        return extra;
    endfunction

    // payload bits carried by a lead byte
    function automatic logic [CP_W-1:0] lead_bits(input logic [7:0] b, input logic [1:0] extra);
        logic [CP_W-1:0] bits;
        unique case (extra)
            2'd3:    bits = {{(CP_W-3){1'b0}}, b[2:0]};
            2'd2:    bits = {{(CP_W-4){1'b0}}, b[3:0]};
            2'd1:    bits = {{(CP_W-5){1'b0}}, b[4:0]};
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

`default_nettype wire

/* design/utf8_stream_decoder_top.sv */
// channel | handshake           | payload
// --------+---------------------+------------------------------------------------
// input   | in_valid, in_stall  | in_byte, end_of_text
// output  | out_valid, out_stall| code_point, is_replacement, run_last, text_done
//
// a transfer steps the held lead and bytes plus the new one (up to four) through
// the shared shift-and-merge unit, then closes the run
// a short sequence kept for the next transfer stops the stepping at its lead
// in_stall is high from the cycle after a transfer until the run closes
// a stalled output freezes the sequencer whenever a result is also pending
// rst_n clears the sequencer, the pending flags and the held byte count
`default_nettype none

module utf8_stream_decoder_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    end_of_text,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [u8d_pkg::CP_W-1:0]     code_point,
    output logic                         is_replacement,
    output logic                         run_last,
    output logic                         text_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_CONT = 2'd2;

    localparam int unsigned CP_W = u8d_pkg::CP_W;

    // control state
    logic [1:0]      state_reg, state_next;
    logic [2:0]      rem_reg, rem_next;
    logic            held_seq_reg, held_seq_next;
    logic            end_reg, end_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            out_valid_reg, out_valid_next;

    // payload
    logic [7:0]      buf_reg [0:3];
    logic [7:0]      buf_next [0:3];
    logic [CP_W-1:0] acc_reg, acc_next;
    logic [CP_W-1:0] pend_cp_reg, pend_cp_next;
    logic            pend_repl_reg, pend_repl_next;
    logic [CP_W-1:0] out_cp_reg, out_cp_next;
    logic            out_repl_reg, out_repl_next;
    logic            out_last_reg, out_last_next;
    logic            out_done_reg, out_done_next;

    // step decisions
    logic            go;
    logic            emit_en;
    logic [CP_W-1:0] emit_cp;
    logic            emit_repl;
    logic            finish_en;
    logic [7:0]      head;
    logic [1:0]      extra;
    logic            short_seq;
    logic [CP_W-1:0] acc_merged;

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign code_point     = out_cp_reg;
    assign is_replacement = out_repl_reg;
    assign run_last       = out_last_reg;
    assign text_done      = out_done_reg;

    assign head       = buf_reg[0];
    assign extra      = u8d_pkg::lead_extra(head);
    assign short_seq  = ((3'(extra) + 3'd1) > rem_reg);
    assign acc_merged = {acc_reg[CP_W-7:0], head[5:0]};

    // a step may run when it has room to hand a pending result on
    assign go = !pend_valid_reg || !out_valid_reg || !out_stall;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        held_seq_next   = held_seq_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        pend_valid_next = pend_valid_reg;
        pend_cp_next    = pend_cp_reg;
        pend_repl_next  = pend_repl_reg;
        out_valid_next  = out_valid_reg;
        out_cp_next     = out_cp_reg;
        out_repl_next   = out_repl_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        for (int i = 0; i < 4; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        emit_en   = 1'b0;
        emit_cp   = '0;
        emit_repl = 1'b0;
        finish_en = 1'b0;

        // output transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    end_next      = end_of_text;
                    held_seq_next = 1'b0;
                    state_next    = S_SCAN;
                    if (held_seq_reg)
                    begin
                        // append after the held lead and bytes
                        for (int i = 0; i < 4; i++)
                        begin
                            if (rem_reg[1:0] == 2'(i))
                            begin
                                buf_next[i] = in_byte;
                            end
                        end
                        rem_next = rem_reg + 3'd1;
                    end
                    else
                    begin
                        buf_next[0] = in_byte;
                        rem_next    = 3'd1;
                    end
                end
            end
            S_SCAN:
            begin
                if (go)
                begin
                    priority if (rem_reg == 3'd0)
                    begin
                        finish_en = 1'b1;
                    end
                    else if (extra != 2'd0 && short_seq && !end_reg)
                    begin
                        // keep the lead and its bytes for the next transfer
                        held_seq_next = 1'b1;
                        finish_en     = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            buf_next[i] = buf_reg[i+1];
                        end
                        rem_next = rem_reg - 3'd1;
                        priority if (!head[7])
                        begin
                            emit_en = 1'b1;
                            emit_cp = {{(CP_W-8){1'b0}}, head};
                        end
                        else if (extra == 2'd0 || short_seq)
                        begin
                            emit_en   = 1'b1;
                            emit_cp   = u8d_pkg::REPLACEMENT;
                            emit_repl = 1'b1;
                        end
                        else
                        begin
                            acc_next   = u8d_pkg::lead_bits(head, extra);
                            cnt_next   = extra;
                            state_next = S_CONT;
                        end
                    end
                end
            end
            S_CONT:
            begin
                if (go)
                begin
                    // continuation is consumed whether good or bad
                    for (int i = 0; i < 3; i++)
                    begin
                        buf_next[i] = buf_reg[i+1];
                    end
                    rem_next = rem_reg - 3'd1;
                    priority if (head[7:6] != 2'b10)
                    begin
                        emit_en    = 1'b1;
                        emit_cp    = u8d_pkg::REPLACEMENT;
                        emit_repl  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else if (cnt_reg == 2'd1)
                    begin
                        emit_en    = 1'b1;
                        emit_cp    = acc_merged;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        acc_next = acc_merged;
                        cnt_next = cnt_reg - 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new result pushes the pending one out, not yet last
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_cp_next    = pend_cp_reg;
                out_repl_next  = pend_repl_reg;
                out_last_next  = 1'b0;
                out_done_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_cp_next    = emit_cp;
            pend_repl_next  = emit_repl;
        end

        // closing the run marks the pending result as last
        if (finish_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_cp_next    = pend_cp_reg;
                out_repl_next  = pend_repl_reg;
                out_last_next  = 1'b1;
                out_done_next  = end_reg;
            end
            pend_valid_next = 1'b0;
            state_next      = S_IDLE;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rem_reg        <= 3'd0;
            held_seq_reg   <= 1'b0;
            end_reg        <= 1'b0;
            cnt_reg        <= 2'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rem_reg        <= rem_next;
            held_seq_reg   <= held_seq_next;
            end_reg        <= end_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
        acc_reg       <= acc_next;
        pend_cp_reg   <= pend_cp_next;
        pend_repl_reg <= pend_repl_next;
        out_cp_reg    <= out_cp_next;
        out_repl_reg  <= out_repl_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

endmodule

`default_nettype wire

/* design/u8d_checker.sv */
`default_nettype none

module u8d_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [u8d_pkg::CP_W-1:0] code_point,
    input wire logic                    is_replacement,
    input wire logic                    run_last,
    input wire logic                    text_done
);

    // replacement flag always carries the replacement character
    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_replacement |-> code_point == u8d_pkg::REPLACEMENT)
        else $error("replacement flag without replacement code point");

    // end of text only on the last result of a byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> run_last)
        else $error("text end on a result that is not last");

    // one byte at a time: busy straight after an input transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without working the byte");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(run_last))
        else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_point     (code_point),
    .is_replacement (is_replacement),
    .run_last       (run_last),
    .text_done      (text_done)
);

`default_nettype wire
